>>> hw/rtl/pec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pec_pkg;

    // default sizes
    localparam int DEF_CHANNELS    = 2;
    localparam int DEF_SAMPLE_BITS = 24;

    // register field widths
    localparam int THRESH_W   = 23;
    localparam int COEFF_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // gain formats: Q1.16 gain, Q2.14 makeup, product of both feeds the output multiply
    localparam int GAIN_FRAC    = 16;
    localparam int GAIN_W       = GAIN_FRAC + 1;
    localparam int GM_W         = GAIN_W + COEFF_W;
    localparam int OUT_SHIFT    = 30;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0] GAIN_MIN = GAIN_W'(6554);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_RATIO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAKEUP    = 3'd4;

    // register reset values
    localparam logic [THRESH_W-1:0] RST_THRESHOLD = 23'd4194304;
    localparam logic [COEFF_W-1:0]  RST_INV_RATIO = 16'd16384;
    localparam logic [COEFF_W-1:0]  RST_ATTACK    = 16'd6554;
    localparam logic [COEFF_W-1:0]  RST_RELEASE   = 16'd66;
    localparam logic [COEFF_W-1:0]  RST_MAKEUP    = 16'd16384;

    // live register set
    typedef struct packed {
        logic [THRESH_W-1:0] threshold_level;
        logic [COEFF_W-1:0]  inverse_ratio;
        logic [COEFF_W-1:0]  attack_coeff;
        logic [COEFF_W-1:0]  release_coeff;
        logic [COEFF_W-1:0]  makeup_gain;
    } cfg_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic                 done;
        logic [GAIN_FRAC-1:0] quot;
    } div_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/pec_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module pec_mul #(
    parameter int AW = pec_pkg::DEF_SAMPLE_BITS,
    parameter int BW = pec_pkg::GM_W
) (
    input  wire logic             clk,
    input  wire logic [AW-1:0]    a,
    input  wire logic [BW-1:0]    b,
    output logic      [AW+BW-1:0] p
);
    import pec_pkg::*;

    logic [AW+BW-1:0] p_reg;
    logic [AW+BW-1:0] p_next;

    // unsigned product, registered
    always_comb
    begin
        p_next = (AW+BW)'(a) * (AW+BW)'(b);
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pec_div.sv
`timescale 1ns / 1ps
`default_nettype none

module pec_div #(
    parameter int W = pec_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [W-1:0]        num,
    input  wire logic [W-1:0]        den,
    output pec_pkg::div_status_t     status
);
    import pec_pkg::*;

    localparam int CNT_W = $clog2(GAIN_FRAC + 1);

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [CNT_W-1:0]     cnt_reg,   cnt_next;
    logic [W-1:0]         rem_reg,   rem_next;
    logic [W-1:0]         den_reg,   den_next;
    logic [GAIN_FRAC-1:0] quot_reg,  quot_next;
    logic [W:0]           rem_shift;
    logic [W:0]           rem_sub;
    logic                 fits;

    // one restoring step per cycle, numerator below divisor so all bits are fraction
    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        rem_sub   = rem_shift - {1'b0, den_reg};
        fits      = rem_shift >= {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(GAIN_FRAC);
            rem_next  = num;
            den_next  = den;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? rem_sub[W-1:0] : rem_shift[W-1:0];
            quot_next = {quot_reg[GAIN_FRAC-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            quot_reg <= quot_next;
        end
    end

    assign status.done = done_reg;
    assign status.quot = quot_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pec_core.sv
`timescale 1ns / 1ps
`default_nettype none

module pec_core #(
    parameter int CHANNELS    = pec_pkg::DEF_CHANNELS,
    parameter int SAMPLE_BITS = pec_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire pec_pkg::cfg_t                        cfg,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 channel,
    input  wire logic signed [SAMPLE_BITS-1:0]        sample_in,
    output logic [SAMPLE_BITS-1:0]                    mul_a,
    output logic [pec_pkg::GM_W-1:0]                  mul_b,
    input  wire logic [SAMPLE_BITS+pec_pkg::GM_W-1:0] mul_p,
    output logic                                      div_start,
    output logic [SAMPLE_BITS-1:0]                    div_num,
    output logic [SAMPLE_BITS-1:0]                    div_den,
    input  wire pec_pkg::div_status_t                 div_stat,
    output logic                                      res_valid,
    input  wire logic                                 res_ready,
    output logic                                      res_channel,
    output logic signed [SAMPLE_BITS-1:0]             res_sample
);
    import pec_pkg::*;

    localparam int B     = SAMPLE_BITS;
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EXT_W = (B > THRESH_W) ? B : THRESH_W;
    localparam int PW    = B + GM_W;
    localparam int YW    = PW - OUT_SHIFT;
    localparam logic [B+COEFF_W:0] ROUND_UP = (B+COEFF_W+1)'((1 << COEFF_W) - 1);
    localparam logic [YW-1:0] POS_LIM = YW'((64'd1 << (B - 1)) - 64'd1);
    localparam logic [YW-1:0] NEG_LIM = YW'(64'd1 << (B - 1));

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENV_MUL,
        S_ENV_UPD,
        S_COMP_MUL,
        S_COMP_DONE,
        S_DIV,
        S_GAIN_MUL,
        S_GAIN_DONE,
        S_OUT_MUL,
        S_OUT_DONE,
        S_RESULT
    } state_t;

    state_t              state_reg,   state_next;
    logic [B-1:0]        env_reg      [CHANNELS];
    logic [B-1:0]        env_next     [CHANNELS];
    logic [CH_W-1:0]     ch_sel_reg,  ch_sel_next;
    logic                ch_in_reg,   ch_in_next;
    logic                neg_reg,     neg_next;
    logic [B-1:0]        mag_reg,     mag_next;
    logic [B-1:0]        env_cur_reg, env_cur_next;
    logic                rise_reg,    rise_next;
    logic [GAIN_W-1:0]   gain_reg,    gain_next;
    logic [GM_W-1:0]     g2_reg,      g2_next;
    logic [B-1:0]        res_reg,     res_next;

    logic [CH_W-1:0]     ch_sel;
    logic [B-1:0]        s_u;
    logic [B-1:0]        mag;
    logic                rise;
    logic [B-1:0]        env_diff;
    logic [B-1:0]        rise_amt;
    logic [B+COEFF_W:0]  fall_sum;
    logic [B-1:0]        fall_amt;
    logic [B-1:0]        env_new;
    logic                above;
    logic [EXT_W-1:0]    thr_x;
    logic [EXT_W-1:0]    excess_x;
    logic [EXT_W-1:0]    knee_x;
    logic [YW-1:0]       y;
    logic [YW-1:0]       y_lim;
    logic [B-1:0]        res_val;

    // datapath around the shared multiplier
    always_comb
    begin
        ch_sel   = (CHANNELS > 1) ? CH_W'(channel) : '0;
        s_u      = sample_in;
        mag      = s_u[B-1] ? (~s_u + B'(1)) : s_u;

        rise     = mag_reg > env_cur_reg;
        env_diff = rise ? (mag_reg - env_cur_reg) : (env_cur_reg - mag_reg);

        // rise truncates, fall rounds the step up
        rise_amt = mul_p[B+COEFF_W-1:COEFF_W];
        fall_sum = {1'b0, mul_p[B+COEFF_W-1:0]} + ROUND_UP;
        fall_amt = fall_sum[B+COEFF_W-1:COEFF_W];
        env_new  = rise_reg ? (env_cur_reg + rise_amt) : (env_cur_reg - fall_amt);

        thr_x    = EXT_W'(cfg.threshold_level);
        above    = EXT_W'(env_new) > thr_x;
        excess_x = EXT_W'(env_cur_reg) - thr_x;
        knee_x   = thr_x + EXT_W'(mul_p[B+COEFF_W-1:COEFF_W]);

        // output scaling, saturation and sign
        y        = mul_p[PW-1:OUT_SHIFT];
        if (neg_reg)
        begin
            y_lim   = (y > NEG_LIM) ? NEG_LIM : y;
            res_val = B'(0) - y_lim[B-1:0];
        end
        else
        begin
            y_lim   = (y > POS_LIM) ? POS_LIM : y;
            res_val = y_lim[B-1:0];
        end
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_ENV_MUL:
            begin
                mul_a = env_diff;
                mul_b = rise ? GM_W'(cfg.attack_coeff) : GM_W'(cfg.release_coeff);
            end
            S_COMP_MUL:
            begin
                mul_a = excess_x[B-1:0];
                mul_b = GM_W'(cfg.inverse_ratio);
            end
            S_GAIN_MUL:
            begin
                mul_a = B'(cfg.makeup_gain);
                mul_b = GM_W'(gain_reg);
            end
            S_OUT_MUL:
            begin
                mul_a = mag_reg;
                mul_b = g2_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        env_next     = env_reg;
        ch_sel_next  = ch_sel_reg;
        ch_in_next   = ch_in_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        env_cur_next = env_cur_reg;
        rise_next    = rise_reg;
        gain_next    = gain_reg;
        g2_next      = g2_reg;
        res_next     = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ch_sel_next  = ch_sel;
                    ch_in_next   = channel;
                    neg_next     = s_u[B-1];
                    mag_next     = mag;
                    env_cur_next = env_reg[ch_sel];
                    state_next   = S_ENV_MUL;
                end
            end
            S_ENV_MUL:
            begin
                rise_next  = rise;
                state_next = S_ENV_UPD;
            end
            S_ENV_UPD:
            begin
                env_next[ch_sel_reg] = env_new;
                env_cur_next         = env_new;
                gain_next            = GAIN_ONE;
                state_next           = above ? S_COMP_MUL : S_GAIN_MUL;
            end
            S_COMP_MUL:
            begin
                state_next = S_COMP_DONE;
            end
            S_COMP_DONE:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    gain_next  = (GAIN_W'(div_stat.quot) < GAIN_MIN) ?
                                 GAIN_MIN : GAIN_W'(div_stat.quot);
                    state_next = S_GAIN_MUL;
                end
            end
            S_GAIN_MUL:
            begin
                state_next = S_GAIN_DONE;
            end
            S_GAIN_DONE:
            begin
                g2_next    = mul_p[GM_W-1:0];
                state_next = S_OUT_MUL;
            end
            S_OUT_MUL:
            begin
                state_next = S_OUT_DONE;
            end
            S_OUT_DONE:
            begin
                res_next   = res_val;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            for (int i = 0; i < CHANNELS; i++)
            begin
                env_reg[i] <= '0;
            end
            ch_sel_reg  <= '0;
            ch_in_reg   <= 1'b0;
            neg_reg     <= 1'b0;
            mag_reg     <= '0;
            env_cur_reg <= '0;
            rise_reg    <= 1'b0;
            gain_reg    <= '0;
            g2_reg      <= '0;
            res_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            env_reg     <= env_next;
            ch_sel_reg  <= ch_sel_next;
            ch_in_reg   <= ch_in_next;
            neg_reg     <= neg_next;
            mag_reg     <= mag_next;
            env_cur_reg <= env_cur_next;
            rise_reg    <= rise_next;
            gain_reg    <= gain_next;
            g2_reg      <= g2_next;
            res_reg     <= res_next;
        end
    end

    // divider feed: knee level over the new envelope
    assign div_start   = (state_reg == S_COMP_DONE);
    assign div_num     = knee_x[B-1:0];
    assign div_den     = env_cur_reg;

    assign in_ready    = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_RESULT);
    assign res_channel = ch_in_reg;
    assign res_sample  = res_reg;

endmodule

`default_nettype wire

>>> hw/rtl/peak_envelope_audio_compressor.sv
// Peak-envelope feed-forward compressor for interleaved audio channels.
// Input channel: in_valid / in_stall with channel and sample_in; a request is
// taken when in_valid is high and in_stall is low. Output channel: out_valid /
// out_stall with channel_out and sample_out, one result for every request.
// Settings are written on cfg_valid / cfg_ready (cfg_ready is always high):
// 0 threshold, 1 inverse ratio, 2 attack, 3 release, 4 makeup gain; write them
// only while no request is in flight.
// From acceptance a request passes the envelope multiply and update, then above
// the threshold the knee multiply and the gain division, then the makeup and
// output multiplies; a new request is taken once the last result is registered.
// One multiplier is shared by the envelope, knee, makeup and output products,
// and a bit-serial divider forms the gain.
// A finished result sits in the output register while the next request is
// worked on; if out_stall holds, the sequencer waits at its final step.
// Reset clears the per-channel envelopes to zero and loads the default settings.
`timescale 1ns / 1ps
`default_nettype none

module peak_envelope_audio_compressor #(
    parameter int CHANNELS    = pec_pkg::DEF_CHANNELS,
    parameter int SAMPLE_BITS = pec_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            channel,
    input  wire logic signed [SAMPLE_BITS-1:0]   sample_in,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 channel_out,
    output logic signed [SAMPLE_BITS-1:0]        sample_out,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pec_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pec_pkg::*;

    cfg_t                           cfg_reg,       cfg_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           ch_out_reg,    ch_out_next;
    logic signed [SAMPLE_BITS-1:0]  smp_out_reg,   smp_out_next;

    logic                           core_ready;
    logic [SAMPLE_BITS-1:0]         mul_a;
    logic [GM_W-1:0]                mul_b;
    logic [SAMPLE_BITS+GM_W-1:0]    mul_p;
    logic                           div_start;
    logic [SAMPLE_BITS-1:0]         div_num;
    logic [SAMPLE_BITS-1:0]         div_den;
    div_status_t                    div_stat;
    logic                           res_valid;
    logic                           res_ready;
    logic                           res_channel;
    logic signed [SAMPLE_BITS-1:0]  res_sample;

    // setting writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_THRESHOLD: cfg_next.threshold_level = cfg_data[THRESH_W-1:0];
                CFG_INV_RATIO: cfg_next.inverse_ratio   = cfg_data[COEFF_W-1:0];
                CFG_ATTACK:    cfg_next.attack_coeff    = cfg_data[COEFF_W-1:0];
                CFG_RELEASE:   cfg_next.release_coeff   = cfg_data[COEFF_W-1:0];
                CFG_MAKEUP:    cfg_next.makeup_gain     = cfg_data[COEFF_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // output register
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        ch_out_next    = ch_out_reg;
        smp_out_next   = smp_out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            ch_out_next    = res_channel;
            smp_out_next   = res_sample;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_level <= RST_THRESHOLD;
            cfg_reg.inverse_ratio   <= RST_INV_RATIO;
            cfg_reg.attack_coeff    <= RST_ATTACK;
            cfg_reg.release_coeff   <= RST_RELEASE;
            cfg_reg.makeup_gain     <= RST_MAKEUP;
            out_valid_reg           <= 1'b0;
            ch_out_reg              <= 1'b0;
            smp_out_reg             <= '0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
            ch_out_reg    <= ch_out_next;
            smp_out_reg   <= smp_out_next;
        end
    end

    // shared multiplier
    pec_mul #(
        .AW (SAMPLE_BITS),
        .BW (GM_W)
    ) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // gain divider
    pec_div #(
        .W (SAMPLE_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .status (div_stat)
    );

    // sequencer and envelope store
    pec_core #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (core_ready),
        .channel     (channel),
        .sample_in   (sample_in),
        .mul_a       (mul_a),
        .mul_b       (mul_b),
        .mul_p       (mul_p),
        .div_start   (div_start),
        .div_num     (div_num),
        .div_den     (div_den),
        .div_stat    (div_stat),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_channel (res_channel),
        .res_sample  (res_sample)
    );

    assign in_stall    = !core_ready;
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign channel_out = ch_out_reg;
    assign sample_out  = smp_out_reg;

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import pec_pkg::*;

    localparam int SB = DEF_SAMPLE_BITS;

    localparam logic [SB-1:0] SMP_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic [THRESH_W-1:0] THRESH_MAX = {THRESH_W{1'b1}};
    localparam logic [COEFF_W-1:0] COEFF_MAX = {COEFF_W{1'b1}};

    // register slots that the block does not implement
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_C = 3'd7;

    typedef struct {
        logic          ch;
        logic [SB-1:0] smp;
    } sample_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic channel = 1'b0;
    logic signed [SB-1:0] sample_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic channel_out;
    logic signed [SB-1:0] sample_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // shadow copy of the block settings and envelopes
    logic [THRESH_W-1:0] thr_reg;
    logic [COEFF_W-1:0] inv_ratio_reg;
    logic [COEFF_W-1:0] attack_reg;
    logic [COEFF_W-1:0] release_reg;
    logic [COEFF_W-1:0] makeup_reg;
    logic [SB-1:0] env_level [DEF_CHANNELS];

    sample_result_t pending_samples [$];
    int mismatch_count = 0;
    int tx_gap_max = 8;
    int rx_wait_max = 8;
    int rx_hold = 0;

    peak_envelope_audio_compressor dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .channel     (channel),
        .sample_in   (sample_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .channel_out (channel_out),
        .sample_out  (sample_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #400000;
        $display("testbench NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // envelope follower, knee gain and makeup, one sample
    function automatic logic [SB-1:0] compress_sample(input logic ch, input logic signed [SB-1:0] s);
        longint sv;
        logic [63:0] mag;
        logic [63:0] env;
        logic [63:0] thr;
        logic [63:0] comp;
        logic [63:0] gain;
        logic [63:0] y;
        logic [63:0] pos_max;
        sv = s;
        mag = (sv < 0) ? 64'(-sv) : 64'(sv);
        env = 64'(env_level[ch]);
        thr = 64'(thr_reg);
        pos_max = (64'd1 << (SB - 1)) - 64'd1;
        // attack on rise, rounded-up release on fall
        if (mag > env)
            env = env + (((mag - env) * 64'(attack_reg)) >> 16);
        else
            env = env - (((env - mag) * 64'(release_reg) + 64'd65535) >> 16);
        env = env & ((64'd1 << SB) - 64'd1);
        env_level[ch] = env[SB-1:0];
        // gain above the threshold
        gain = 64'(GAIN_ONE);
        if (env > thr)
        begin
            comp = ((env - thr) * 64'(inv_ratio_reg)) >> 16;
            gain = ((thr + comp) << 16) / env;
            if (gain > 64'(GAIN_ONE))
                gain = 64'(GAIN_ONE);
            if (gain < 64'(GAIN_MIN))
                gain = 64'(GAIN_MIN);
        end
        // scale magnitude, restore sign, saturate
        y = (mag * gain * 64'(makeup_reg)) >> OUT_SHIFT;
        if (sv < 0)
        begin
            if (y > pos_max + 64'd1)
                y = pos_max + 64'd1;
            y = 64'd0 - y;
        end
        else if (y > pos_max)
            y = pos_max;
        return y[SB-1:0];
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_THRESHOLD: thr_reg = val[THRESH_W-1:0];
            CFG_INV_RATIO: inv_ratio_reg = val[COEFF_W-1:0];
            CFG_ATTACK:    attack_reg = val[COEFF_W-1:0];
            CFG_RELEASE:   release_reg = val[COEFF_W-1:0];
            CFG_MAKEUP:    makeup_reg = val[COEFF_W-1:0];
            default:       ;
        endcase
    endfunction

    // register write, only called while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_settings(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] ir,
                                  input logic [CFG_DATA_W-1:0] att, input logic [CFG_DATA_W-1:0] rel,
                                  input logic [CFG_DATA_W-1:0] mk);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_INV_RATIO, ir);
        write_reg(CFG_ATTACK, att);
        write_reg(CFG_RELEASE, rel);
        write_reg(CFG_MAKEUP, mk);
    endtask

    // offer one sample request after a random gap, predict it once taken
    task automatic send_sample(input logic ch, input logic [SB-1:0] s);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        channel <= ch;
        sample_in <= s;
        do @(posedge clk); while (in_stall);
        pending_samples.push_back(sample_result_t'{ch, compress_sample(ch, s)});
    endtask

    // stop offering, let every result drain, then allow the block to settle
    task automatic wait_idle();
        int guard;
        guard = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_samples.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        while (pending_samples.size() != 0)
        begin
            report_mismatch("missing result, sample", 0, longint'($signed(pending_samples[0].smp)));
            void'(pending_samples.pop_front());
        end
        repeat (40) @(posedge clk);
    endtask

    // mostly loud bursts so the envelope climbs past the threshold
    function automatic logic [SB-1:0] pick_sample();
        logic [SB-1:0] m;
        case ($urandom_range(0, 9))
            0: m = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
            1, 2, 3, 4, 5:
            begin
                m = SB'($urandom_range(1 << (SB - 3), (1 << (SB - 1)) - 1));
                if ($urandom_range(0, 1))
                    m = -m;
            end
            6, 7: m = SB'($urandom());
            8:
            begin
                m = SB'($urandom_range(0, 4095));
                if ($urandom_range(0, 1))
                    m = -m;
            end
            default: m = '0;
        endcase
        return m;
    endfunction

    task automatic pick_settings();
        logic [CFG_DATA_W-1:0] thr;
        logic [CFG_DATA_W-1:0] ir;
        logic [CFG_DATA_W-1:0] att;
        logic [CFG_DATA_W-1:0] rel;
        logic [CFG_DATA_W-1:0] mk;
        case ($urandom_range(0, 5))
            0: thr = '0;
            1: thr = CFG_DATA_W'(THRESH_MAX);
            default: thr = CFG_DATA_W'($urandom_range(0, (1 << THRESH_W) - 1));
        endcase
        ir = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(32769, 65535))
                                         : CFG_DATA_W'($urandom_range(0, 32768));
        case ($urandom_range(0, 7))
            0: att = '0;
            1: att = CFG_DATA_W'(COEFF_MAX);
            default: att = CFG_DATA_W'($urandom_range(2048, 65535));
        endcase
        case ($urandom_range(0, 7))
            0: rel = '0;
            1: rel = CFG_DATA_W'(COEFF_MAX);
            default: rel = CFG_DATA_W'($urandom_range(0, 8192));
        endcase
        case ($urandom_range(0, 7))
            0: mk = '0;
            1: mk = CFG_DATA_W'(COEFF_MAX);
            default: mk = CFG_DATA_W'($urandom_range(8192, 49152));
        endcase
        write_settings(thr, ir, att, rel, mk);
        if ($urandom_range(0, 1))
            write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom()));
    endtask

    // result receiver with random stalls and an optional long hold-off
    initial
    begin : result_sink
        int n;
        forever
        begin
            if (rx_hold > 0)
            begin
                n = rx_hold;
                rx_hold = 0;
            end
            else
                n = $urandom_range(0, rx_wait_max);
            if (n > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : result_check
        sample_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_samples.size() == 0)
                report_mismatch("unexpected result, sample", longint'(sample_out), 0);
            else
            begin
                want = pending_samples.pop_front();
                if (channel_out !== want.ch)
                    report_mismatch("channel_out", longint'(channel_out), longint'(want.ch));
                if (sample_out !== want.smp)
                    report_mismatch("sample_out", longint'(sample_out),
                                    longint'($signed(want.smp)));
            end
        end
    end

    // defaults after reset with full-scale and tiny samples
    task automatic test_reset_defaults();
        send_sample(1'b0, '0);
        send_sample(1'b0, SMP_MAX);
        send_sample(1'b0, SMP_MAX);
        send_sample(1'b0, SMP_MAX);
        send_sample(1'b1, SMP_MIN);
        send_sample(1'b1, SMP_MIN);
        send_sample(1'b0, '1);
        send_sample(1'b1, SB'(1));
        send_sample(1'b0, '0);
        wait_idle();
    endtask

    // extreme register values, spare slots, zero coefficients, wide data masked
    task automatic test_register_extremes();
        write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom()));
        write_reg(CFG_SPARE_B, '1);
        write_reg(CFG_SPARE_C, CFG_DATA_W'($urandom()));
        // inverse ratio just below one, near-instant attack and release
        write_settings('0, CFG_DATA_W'(COEFF_MAX), CFG_DATA_W'(COEFF_MAX),
                       CFG_DATA_W'(COEFF_MAX), CFG_DATA_W'(COEFF_MAX));
        send_sample(1'b0, SMP_MAX);
        send_sample(1'b1, SMP_MIN);
        send_sample(1'b0, SB'(12345));
        send_sample(1'b1, -SB'(4000000));
        wait_idle();
        // zero coefficients hold the envelopes, zero makeup mutes
        write_settings(CFG_DATA_W'(THRESH_MAX), '0, '0, '0, '0);
        send_sample(1'b0, SMP_MAX);
        send_sample(1'b0, '0);
        send_sample(1'b1, SMP_MIN);
        wait_idle();
        // coefficient data with upper bits set
        write_settings(CFG_DATA_W'(1), '0, '1, '0, CFG_DATA_W'(RST_MAKEUP));
        send_sample(1'b0, SMP_MAX);
        send_sample(1'b0, SMP_MIN);
        send_sample(1'b1, SB'(100));
        send_sample(1'b1, '0);
        wait_idle();
    endtask

    // random settings per phase with random samples
    task automatic test_random_settings();
        for (int phase = 0; phase < 6; phase++)
        begin
            tx_gap_max = (phase == 1) ? 0 : 8;
            rx_wait_max = (phase == 1 || phase == 4) ? 0 : 8;
            pick_settings();
            for (int k = 0; k < 80; k++)
                send_sample(1'($urandom_range(0, 1)), pick_sample());
            wait_idle();
        end
        tx_gap_max = 8;
        rx_wait_max = 8;
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure();
        pick_settings();
        tx_gap_max = 0;
        rx_hold = 300;
        for (int k = 0; k < 24; k++)
            send_sample(1'($urandom_range(0, 1)), pick_sample());
        wait_idle();
        tx_gap_max = 8;
    endtask

    initial
    begin : main_sequence
        thr_reg = RST_THRESHOLD;
        inv_ratio_reg = RST_INV_RATIO;
        attack_reg = RST_ATTACK;
        release_reg = RST_RELEASE;
        makeup_reg = RST_MAKEUP;
        for (int c = 0; c < DEF_CHANNELS; c++)
            env_level[c] = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_random_settings();
        test_backpressure();
        if (mismatch_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
